FILE: design/strmi_pkg.sv
// Shared types, sizes and helpers for the sparse-table range-minimum engine.
// No dependencies; used by sparse_table_range_min_index and the testbench (strmi_ram does not use it).
package strmi_pkg;

  localparam int ValueBits   = 32;
  localparam int MaxElements = 1024;
  localparam int Levels      = 11;

  localparam int PosW     = 10;                      // element position
  localparam int CntW     = 11;                      // element count / range end
  localparam int LvlW     = $clog2(Levels);          // level number
  localparam int LvlDepth = (Levels - 1) * MaxElements;  // levels 1.. stored
  localparam int LvlAw    = LvlW + PosW;             // {level slot, position}

  typedef enum logic [0:0] {
    CmdLoad  = 1'b0,
    CmdQuery = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    StatOk  = 1'b0,
    StatBad = 1'b1
  } status_e;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StQAddr  = 6'b000010,
    StQTbl   = 6'b000100,
    StQDone  = 6'b001000,
    StBRun   = 6'b010000,
    StBDrain = 6'b100000
  } state_e;

  // Largest level whose span fits in len, capped at the top level.
  function automatic logic [LvlW-1:0] span_level(logic [CntW-1:0] len);
    int b;
    b = 0;
    for (int i = 1; i < CntW; i++) begin
      if (len[i]) begin
        b = i;
      end
    end
    if (b > Levels - 1) begin
      b = Levels - 1;
    end
    return LvlW'(b);
  endfunction

endpackage

FILE: design/strmi_ram.sv
// Synchronous RAM, one write port and two read ports, registered read data.
// Used for the element values and for the level index table; no package use.
module strmi_ram #(
  parameter int DataW = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr0_i,
  input  logic [$clog2(Depth)-1:0] raddr1_i,
  output logic [DataW-1:0]         rdata0_o,
  output logic [DataW-1:0]         rdata1_o
);

  logic [DataW-1:0] mem [0:Depth-1];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule

FILE: design/sparse_table_range_min_index.sv
// Sparse-table range-minimum engine: top level, control and build pipeline.
// Load: a load at position element_count-1 starts the table build, input not ready meanwhile.
// Query: table read (none at level 0), then value read, then result registered; a bad range
//   skips both reads. No new query is taken until the result is registered, which waits on a stalled output.
// Reset: control cleared, element_count = 1024, table not ready; RAMs keep contents.
// Depends on strmi_pkg and strmi_ram.
module sparse_table_range_min_index #(
  parameter int VALUE_BITS = strmi_pkg::ValueBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [strmi_pkg::PosW-1:0]  position_i,
  input  logic signed [VALUE_BITS-1:0] element_value_i,
  input  logic [strmi_pkg::PosW-1:0]  range_left_i,
  input  logic [strmi_pkg::CntW-1:0]  range_right_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [strmi_pkg::PosW-1:0]  min_position_o,
  output logic signed [VALUE_BITS-1:0] min_value_o,
  output logic                        status_o,
  input  logic                        cfg_we_i,
  input  logic [strmi_pkg::CntW-1:0]  cfg_wdata_i
);

  localparam int PosW = strmi_pkg::PosW;
  localparam int CntW = strmi_pkg::CntW;
  localparam int LvlW = strmi_pkg::LvlW;
  localparam int LvlAw = strmi_pkg::LvlAw;

  strmi_pkg::state_e state_q, state_d;

  logic [CntW-1:0] cfg_count_q, cfg_count_d;
  logic            ready_q, ready_d;

  // query operands
  logic [PosW-1:0] q_left_q, q_left_d;
  logic [CntW-1:0] q_right_q, q_right_d;
  logic            q_bad_q, q_bad_d;

  // level in work (build) or span level (query), issue counter
  logic [LvlW-1:0] k_q, k_d;
  logic [PosW-1:0] j_q, j_d;

  // stage 1: pair of candidate positions (level 0) or table read pending
  logic            p1_valid_q;
  logic [PosW-1:0] p1_j_q, p1_j_d;
  logic [PosW-1:0] p1_a_q, p1_a_d;
  logic [PosW-1:0] p1_b_q, p1_b_d;
  // stage 2: value read pending for two candidate indices
  logic            p2_valid_q;
  logic [PosW-1:0] p2_j_q, p2_j_d;
  logic [PosW-1:0] p2_i0_q, p2_i0_d;
  logic [PosW-1:0] p2_i1_q, p2_i1_d;

  logic                  out_valid_q, out_valid_d;
  logic [PosW-1:0]       out_pos_q, out_pos_d;
  logic [VALUE_BITS-1:0] out_val_q, out_val_d;
  logic                  out_stat_q, out_stat_d;

  // memory ports
  logic                  vm_we, vm_re;
  logic [PosW-1:0]       vm_ra0, vm_ra1;
  logic [VALUE_BITS-1:0] vm_rd0, vm_rd1;
  logic                  lm_we, lm_re;
  logic [LvlAw-1:0]      lm_wa, lm_ra0, lm_ra1;
  logic [PosW-1:0]       lm_wd, lm_rd0, lm_rd1;

  logic [CntW-1:0] n_act;
  logic [CntW-1:0] half, two_half, last_j, q_len, q_sub;
  logic [CntW:0]   next_span;
  logic [LvlW-1:0] q_lvl;
  logic            accept, is_query, out_free, first_wins;
  logic [PosW-1:0] cand0, cand1, best_idx;
  logic [VALUE_BITS-1:0] best_val;

  strmi_ram #(
    .DataW (VALUE_BITS),
    .Depth (strmi_pkg::MaxElements)
  ) u_value_ram (
    .clk_i    (clk_i),
    .we_i     (vm_we),
    .waddr_i  (position_i),
    .wdata_i  (element_value_i),
    .re_i     (vm_re),
    .raddr0_i (vm_ra0),
    .raddr1_i (vm_ra1),
    .rdata0_o (vm_rd0),
    .rdata1_o (vm_rd1)
  );

  strmi_ram #(
    .DataW (PosW),
    .Depth (strmi_pkg::LvlDepth)
  ) u_level_ram (
    .clk_i    (clk_i),
    .we_i     (lm_we),
    .waddr_i  (lm_wa),
    .wdata_i  (lm_wd),
    .re_i     (lm_re),
    .raddr0_i (lm_ra0),
    .raddr1_i (lm_ra1),
    .rdata0_o (lm_rd0),
    .rdata1_o (lm_rd1)
  );

  // element count as used: zero acts as one, clipped to the store size
  always_comb begin
    if (cfg_count_q == '0) begin
      n_act = CntW'(1);
    end else if (cfg_count_q > CntW'(strmi_pkg::MaxElements)) begin
      n_act = CntW'(strmi_pkg::MaxElements);
    end else begin
      n_act = cfg_count_q;
    end
  end

  assign in_ready_o = (state_q == strmi_pkg::StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign is_query   = (command_i == strmi_pkg::CmdQuery);
  assign out_free   = !out_valid_q || out_ready_i;

  assign half      = CntW'(1) << k_q;
  assign two_half  = half << 1;
  assign last_j    = n_act - two_half;
  assign next_span = {1'b0, two_half} << 1;

  assign q_len = q_right_q - {1'b0, q_left_q};
  assign q_lvl = strmi_pkg::span_level(q_len);
  assign q_sub = q_right_q - (CntW'(1) << q_lvl);

  // stage 1: level 0 entries are the positions themselves
  assign cand0 = (k_q == '0) ? p1_a_q : lm_rd0;
  assign cand1 = (k_q == '0) ? p1_b_q : lm_rd1;

  // stage 2: left index wins a tie
  assign first_wins = ($signed(vm_rd0) <= $signed(vm_rd1));
  assign best_idx   = first_wins ? p2_i0_q : p2_i1_q;
  assign best_val   = first_wins ? vm_rd0 : vm_rd1;

  assign vm_we  = accept && !is_query;
  assign vm_re  = p1_valid_q || (state_q == strmi_pkg::StQTbl);
  assign vm_ra0 = cand0;
  assign vm_ra1 = cand1;

  assign lm_we = p2_valid_q;
  assign lm_wa = {k_q, p2_j_q};
  assign lm_wd = best_idx;

  always_comb begin
    lm_re  = 1'b0;
    lm_ra0 = {k_q - LvlW'(1), j_q};
    lm_ra1 = {k_q - LvlW'(1), j_q + half[PosW-1:0]};
    if (state_q == strmi_pkg::StQAddr) begin
      lm_re  = (q_lvl != '0);
      lm_ra0 = {q_lvl - LvlW'(1), q_left_q};
      lm_ra1 = {q_lvl - LvlW'(1), q_sub[PosW-1:0]};
    end else if (state_q == strmi_pkg::StBRun) begin
      lm_re = (k_q != '0);
    end
  end

  always_comb begin
    state_d     = state_q;
    cfg_count_d = cfg_count_q;
    ready_d     = ready_q;
    q_left_d    = q_left_q;
    q_right_d   = q_right_q;
    q_bad_d     = q_bad_q;
    k_d         = k_q;
    j_d         = j_q;
    p1_j_d      = p1_j_q;
    p1_a_d      = p1_a_q;
    p1_b_d      = p1_b_q;
    p2_j_d      = p1_j_q;
    p2_i0_d     = p2_i0_q;
    p2_i1_d     = p2_i1_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_pos_d   = out_pos_q;
    out_val_d   = out_val_q;
    out_stat_d  = out_stat_q;

    if (cfg_we_i) begin
      cfg_count_d = cfg_wdata_i;
      ready_d     = 1'b0;
    end

    if (vm_re) begin
      p2_i0_d = cand0;
      p2_i1_d = cand1;
    end

    unique case (state_q)
      strmi_pkg::StIdle: begin
        if (accept && is_query) begin
          q_left_d  = range_left_i;
          q_right_d = range_right_i;
          q_bad_d   = !ready_q || ({1'b0, range_left_i} >= range_right_i)
                      || (range_right_i > n_act);
          state_d   = q_bad_d ? strmi_pkg::StQDone : strmi_pkg::StQAddr;
        end else if (accept && ({1'b0, position_i} == n_act - CntW'(1))) begin
          k_d = '0;
          j_d = '0;
          if (n_act >= CntW'(2)) begin
            state_d = strmi_pkg::StBRun;
          end else begin
            ready_d = 1'b1;
          end
        end
      end
      strmi_pkg::StQAddr: begin
        // span level goes to k_q so that stage 1 selection is shared
        k_d     = q_lvl;
        p1_a_d  = q_left_q;
        p1_b_d  = q_sub[PosW-1:0];
        state_d = strmi_pkg::StQTbl;
      end
      strmi_pkg::StQTbl: begin
        state_d = strmi_pkg::StQDone;
      end
      strmi_pkg::StQDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (q_bad_q) begin
            out_pos_d  = '0;
            out_val_d  = '0;
            out_stat_d = strmi_pkg::StatBad;
          end else begin
            out_pos_d  = best_idx;
            out_val_d  = best_val;
            out_stat_d = strmi_pkg::StatOk;
          end
          state_d = strmi_pkg::StIdle;
        end
      end
      strmi_pkg::StBRun: begin
        p1_j_d = j_q;
        p1_a_d = j_q;
        p1_b_d = j_q + half[PosW-1:0];
        if ({1'b0, j_q} == last_j) begin
          state_d = strmi_pkg::StBDrain;
        end else begin
          j_d = j_q + PosW'(1);
        end
      end
      strmi_pkg::StBDrain: begin
        // next level reads what this level wrote: wait for the pipeline
        if (!p1_valid_q && !p2_valid_q) begin
          if ((32'(k_q) + 2 < strmi_pkg::Levels) && (next_span <= {1'b0, n_act})) begin
            k_d     = k_q + LvlW'(1);
            j_d     = '0;
            state_d = strmi_pkg::StBRun;
          end else begin
            ready_d = 1'b1;
            state_d = strmi_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = strmi_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= strmi_pkg::StIdle;
      cfg_count_q <= CntW'(strmi_pkg::MaxElements);
      ready_q     <= 1'b0;
      q_bad_q     <= 1'b0;
      k_q         <= '0;
      j_q         <= '0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_count_q <= cfg_count_d;
      ready_q     <= ready_d;
      q_bad_q     <= q_bad_d;
      k_q         <= k_d;
      j_q         <= j_d;
      p1_valid_q  <= (state_q == strmi_pkg::StBRun);
      p2_valid_q  <= p1_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_left_q   <= q_left_d;
    q_right_q  <= q_right_d;
    p1_j_q     <= p1_j_d;
    p1_a_q     <= p1_a_d;
    p1_b_q     <= p1_b_d;
    p2_j_q     <= p2_j_d;
    p2_i0_q    <= p2_i0_d;
    p2_i1_q    <= p2_i1_d;
    out_pos_q  <= out_pos_d;
    out_val_q  <= out_val_d;
    out_stat_q <= out_stat_d;
  end

  assign out_valid_o    = out_valid_q;
  assign min_position_o = out_pos_q;
  assign min_value_o    = out_val_q;
  assign status_o       = out_stat_q;

endmodule

FILE: dv/tb_top.sv
// Testbench for the sparse-table range-minimum engine: loads, table builds and queries.
// Predicts every query result with its own sparse table and checks each result in order.
// Depends on strmi_pkg and sparse_table_range_min_index.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ValueBits   = strmi_pkg::ValueBits;
  localparam int MaxElements = strmi_pkg::MaxElements;
  localparam int Levels      = strmi_pkg::Levels;
  localparam int PosW        = strmi_pkg::PosW;
  localparam int CntW        = strmi_pkg::CntW;

  localparam int QuietLimit = 50000;
  localparam int RandomItems = 130;
  localparam logic signed [ValueBits-1:0] ValueMin = {1'b1, {(ValueBits-1){1'b0}}};
  localparam logic signed [ValueBits-1:0] ValueMax = {1'b0, {(ValueBits-1){1'b1}}};

  typedef struct {
    logic [PosW-1:0]             pos;
    logic signed [ValueBits-1:0] val;
    strmi_pkg::status_e          st;
  } minimum_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic                        command_i = 1'b0;
  logic [PosW-1:0]             position_i = '0;
  logic signed [ValueBits-1:0] element_value_i = '0;
  logic [PosW-1:0]             range_left_i = '0;
  logic [CntW-1:0]             range_right_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [PosW-1:0]             min_position_o;
  logic signed [ValueBits-1:0] min_value_o;
  logic                        status_o;
  logic                        cfg_we_i = 1'b0;
  logic [CntW-1:0]             cfg_wdata_i = '0;

  sparse_table_range_min_index u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .position_i     (position_i),
    .element_value_i(element_value_i),
    .range_left_i   (range_left_i),
    .range_right_i  (range_right_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .min_position_o (min_position_o),
    .min_value_o    (min_value_o),
    .status_o       (status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Predictor state: element store, doubling levels, build flag, element count.
  logic signed [ValueBits-1:0] value_mem [MaxElements];
  logic [PosW-1:0]             span_tbl [Levels][MaxElements];
  bit                          loaded [MaxElements];
  bit                          built = 1'b0;
  logic [CntW-1:0]             count_reg = CntW'(MaxElements);

  minimum_t pending_minima [$];
  minimum_t head;

  int gap_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  int items_sent = 0;
  int n_loads = 0;
  int n_builds = 0;
  int n_queries = 0;
  int n_bad = 0;
  int n_settings = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_count();
    if (count_reg == 0) begin
      return 1;
    end
    if (count_reg > MaxElements) begin
      return MaxElements;
    end
    return int'(count_reg);
  endfunction

  // Left index wins a tie.
  function automatic logic [PosW-1:0] lesser(logic [PosW-1:0] a, logic [PosW-1:0] b);
    return (value_mem[a] <= value_mem[b]) ? a : b;
  endfunction

  function automatic void rebuild_levels(int n);
    int half;
    for (int i = 0; i < n; i++) begin
      span_tbl[0][i] = PosW'(i);
    end
    for (int k = 0; k + 1 < Levels && (2 << k) <= n; k++) begin
      half = 1 << k;
      for (int j = 0; j + 2 * half <= n; j++) begin
        span_tbl[k+1][j] = lesser(span_tbl[k][j], span_tbl[k][j+half]);
      end
    end
    built = 1'b1;
  endfunction

  function automatic minimum_t range_minimum(logic [PosW-1:0] left, logic [CntW-1:0] right);
    minimum_t        res;
    int              len;
    int              b;
    logic [PosW-1:0] best;
    res.pos = '0;
    res.val = '0;
    res.st  = strmi_pkg::StatBad;
    if (!built || left >= right || right > eff_count()) begin
      return res;
    end
    len = int'(right) - int'(left);
    b = 0;
    while (b + 1 < Levels && (2 << b) <= len) begin
      b++;
    end
    // Two overlapping spans of 2^b cover the range.
    best = lesser(span_tbl[b][left], span_tbl[b][int'(right) - (1 << b)]);
    res.pos = best;
    res.val = value_mem[best];
    res.st  = strmi_pkg::StatOk;
    return res;
  endfunction

  // Rough build time over the levels of the table build, plus margin.
  function automatic int settle_cycles();
    int n;
    int total;
    n = eff_count();
    total = 16;
    for (int k = 0; k + 1 < Levels && (2 << k) <= n; k++) begin
      total += n - (2 << k) + 4;
    end
    return total;
  endfunction

  function automatic logic signed [ValueBits-1:0] pick_value();
    case ($urandom_range(7))
      0: return ValueMin;
      1: return ValueMax;
      2, 3: return int'($urandom_range(6)) - 3;  // small range, plenty of ties
      default: return $urandom();
    endcase
  endfunction

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      1: begin
        gap_pct = 86;
        stall_pct = 0;
      end
      2: begin
        gap_pct = 0;
        stall_pct = 86;
      end
      default: begin
        gap_pct = 8;
        stall_pct = 8;
      end
    endcase
  endtask

  task automatic send_item(strmi_pkg::cmd_e cmd, logic [PosW-1:0] pos,
                           logic signed [ValueBits-1:0] val,
                           logic [PosW-1:0] left, logic [CntW-1:0] right);
    minimum_t res;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    position_i      <= pos;
    element_value_i <= val;
    range_left_i    <= left;
    range_right_i   <= right;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    items_sent++;
    if (cmd == strmi_pkg::CmdLoad) begin
      value_mem[pos] = val;
      loaded[pos] = 1'b1;
      n_loads++;
      if (int'(pos) == eff_count() - 1) begin
        rebuild_levels(eff_count());
        n_builds++;
      end
    end else begin
      res = range_minimum(left, right);
      pending_minima.push_back(res);
      n_queries++;
      if (res.st == strmi_pkg::StatBad) begin
        n_bad++;
      end
    end
  endtask

  // Unused fields carry random junk.
  task automatic send_load(int pos, logic signed [ValueBits-1:0] val);
    send_item(strmi_pkg::CmdLoad, PosW'(pos), val, PosW'($urandom()), CntW'($urandom()));
  endtask

  task automatic send_query(int left, int right);
    send_item(strmi_pkg::CmdQuery, PosW'($urandom()), $urandom(), PosW'(left), CntW'(right));
  endtask

  task automatic random_query(int n);
    int sel;
    int l;
    int r;
    sel = $urandom_range(99);
    if (sel < 8) begin
      l = $urandom_range(MaxElements - 1);
      r = $urandom_range(l);
    end else if (sel < 15) begin
      l = $urandom_range(MaxElements - 1);
      r = $urandom_range(2047, n + 1);
    end else if (sel < 35) begin
      l = $urandom_range(n - 1);
      r = l + 1 + $urandom_range((n - 1 - l < 3) ? n - 1 - l : 3);
    end else begin
      l = $urandom_range(n - 1);
      r = $urandom_range(n, l + 1);
    end
    send_query(l, r);
  endtask

  task automatic random_load(int n);
    int sel;
    int pos;
    sel = $urandom_range(99);
    if (sel < 60) begin
      pos = $urandom_range(n - 1);
    end else if (sel < 75) begin
      pos = n - 1;  // rebuilds the table
    end else begin
      pos = $urandom_range(MaxElements - 1);
    end
    send_load(pos, pick_value());
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_minima.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (settle_cycles()) @(posedge clk_i);
  endtask

  task automatic write_count(int cnt);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CntW'(cnt);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    count_reg = CntW'(cnt);
    built = 1'b0;
    n_settings++;
  endtask

  task automatic report_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    fail_count++;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
  endtask

  // No table yet after reset.
  task automatic test_not_ready();
    set_idling(0);
    send_query(0, 1);
    send_load(3, pick_value());
    send_query(0, 4);
  endtask

  // Extreme values, ties, a query before the build and the bad-range cases.
  task automatic test_small_table();
    set_idling(0);
    write_count(8);
    send_load(0, ValueMax);
    send_load(1, -5);
    send_load(2, ValueMin);
    send_load(3, 3);
    send_load(4, ValueMin);
    send_load(5, -1);
    send_load(6, 0);
    send_query(0, 7);
    send_load(7, -5);
    send_query(0, 8);
    send_query(3, 8);
    send_query(5, 8);
    send_query(0, 1);
    send_query(2, 2);
    send_query(5, 3);
    send_query(0, 9);
    send_query(MaxElements - 1, 2047);
  endtask

  // Overwrite without rebuild: old indices, new values; then a load at the last position rebuilds.
  task automatic test_stale_reload();
    set_idling(0);
    send_load(2, ValueMax);
    send_query(0, 8);
    send_load(7, -5);
    send_query(0, 8);
  endtask

  task automatic test_count_zero();
    set_idling(0);
    write_count(0);
    send_load(0, pick_value());
    send_query(0, 1);
    send_query(0, 2);
  endtask

  task automatic test_full_table();
    set_idling(3);
    write_count(MaxElements);
    for (int p = 0; p < MaxElements; p++) begin
      if ($urandom_range(63) == 0) begin
        random_query(MaxElements);
      end
      send_load(p, pick_value());
    end
    send_query(0, MaxElements);
    send_query(MaxElements - 1, MaxElements);
    repeat (40) random_query(MaxElements);
    // Counts above the store size clamp to it.
    write_count(2047);
    send_query(0, MaxElements);
    send_load(MaxElements - 1, pick_value());
    send_query(0, MaxElements);
    send_query(0, MaxElements + 1);
    repeat (10) random_query(MaxElements);
  endtask

  // At least one phase for each idling mode.
  task automatic test_random_phases();
    int phase;
    int n;
    int sel;
    int stop_at;
    int cnt;
    phase = 0;
    stop_at = items_sent + RandomItems;
    while (items_sent < stop_at || phase < 4) begin
      set_idling(phase % 4);
      sel = $urandom_range(99);
      if (sel < 8) begin
        cnt = 0;
      end else if (sel < 16) begin
        cnt = 1;
      end else if (sel < 20) begin
        cnt = $urandom_range(2047, MaxElements);
      end else if (sel < 28) begin
        cnt = $urandom_range(256, 65);
      end else begin
        cnt = $urandom_range(64, 2);
      end
      write_count(cnt);
      n = eff_count();
      // Fill in order; stray queries before the build see no table.
      for (int p = 0; p < n; p++) begin
        if (n <= 64 || !loaded[p] || p == n - 1) begin
          if (n <= 64 && $urandom_range(9) == 0) begin
            random_query(n);
          end
          send_load(p, pick_value());
        end
      end
      repeat ($urandom_range(40, 10)) begin
        if ($urandom_range(99) < 70) begin
          random_query(n);
        end else begin
          random_load(n);
        end
      end
      phase++;
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_minima.size() == 0) begin
        report_field("unexpected result, min_position", '0, 64'(min_position_o));
      end else begin
        head = pending_minima.pop_front();
        if (min_position_o !== head.pos) begin
          report_field("min_position", 64'(head.pos), 64'(min_position_o));
        end
        if (min_value_o !== head.val) begin
          report_field("min_value", 64'(head.val), 64'(min_value_o));
        end
        if (status_o !== head.st) begin
          report_field("status", 64'(head.st), 64'(status_o));
        end
      end
    end
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, QuietLimit);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_not_ready();
    test_small_table();
    test_stale_reload();
    test_count_zero();
    test_full_table();
    test_random_phases();
    wait_idle();
    $display("Covered %0d loads with %0d table builds over %0d count settings,",
             n_loads, n_builds, n_settings);
    $display("and %0d queries, %0d of them empty, out of range or before a build.",
             n_queries, n_bad);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
